[rtl/spq_pkg.sv]
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int VB_W   = 17;
    localparam int ES_W   = 7;
    localparam int ID_W   = 32;
    localparam int ADDR_W = 64;

    localparam logic [VB_W-1:0] VB_RESET = 17'd8192;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_FILL = 2'd0;
    localparam cmd_t CMD_POP  = 2'd1;
    localparam cmd_t CMD_CMPL = 2'd2;
    localparam cmd_t CMD_PEEK = 2'd3;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NEW  = 2'd0;
    localparam kind_t KIND_POP  = 2'd1;
    localparam kind_t KIND_CMPL = 2'd2;
    localparam kind_t KIND_PEEK = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr_first;
        logic [ADDR_W-1:0] addr_second;
        logic [ADDR_W-1:0] addr_dest;
        logic [ES_W-1:0]   elem_size;
        logic              is_move;
        logic              done;
        logic [ADDR_W-1:0] ready;
    } spq_rec_t;

    localparam int REC_W = $bits(spq_rec_t);

endpackage

[rtl/strided_prefetch_queue_top.sv]
// Strided prefetch queue: a FIFO of up to QUEUE_DEPTH prefetch records held in one
// synchronous RAM. A command is taken when start is high and busy is low; each result
// shows for one cycle under result_strobe and cannot be held off, with last marking the
// final result of a command. Pop and peek make one RAM read, none on an empty queue.
// Fill makes a tail read (skipped on an empty queue), runs the bit-serial stride divider
// (17 steps), then appends records, each advanced by the stride, until the queue is
// full; a fill on a full queue gives no result and leaves busy low. Completion scans
// from the head one RAM read per cycle. The user must see that vector_bytes is written
// only while busy is low; the block itself does not enforce this.
module strided_prefetch_queue_top
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vector_bytes_we,
    input  logic [VB_W-1:0]   vector_bytes_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [ID_W-1:0]   conv_id,
    input  logic [ADDR_W-1:0] addr_first,
    input  logic [ADDR_W-1:0] addr_second,
    input  logic [ADDR_W-1:0] addr_dest,
    input  logic [ES_W-1:0]   elem_size,
    input  logic              is_move,
    input  logic [ADDR_W-1:0] ready_cycle,
    output logic              result_strobe,
    output logic [1:0]        kind,
    output logic              ok,
    output logic [ID_W-1:0]   rec_id,
    output logic [ADDR_W-1:0] rec_addr_first,
    output logic [ADDR_W-1:0] rec_addr_second,
    output logic [ADDR_W-1:0] rec_addr_dest,
    output logic [ES_W-1:0]   rec_elem_size,
    output logic              rec_is_move,
    output logic              rec_done,
    output logic [ADDR_W-1:0] rec_ready,
    output logic              last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RDWAIT = 5'b00010,
        S_DIV    = 5'b00100,
        S_FILL   = 5'b01000,
        S_SCAN   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [VB_W-1:0]   vb_reg;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic [PTR_W-1:0]  pend_addr_reg, pend_addr_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ID_W-1:0]   cid_reg, cid_next;
    logic [ADDR_W-1:0] rdy_reg, rdy_next;
    spq_rec_t          base_reg, base_next;

    logic              strobe_reg;
    kind_t             kind_reg;
    logic              ok_reg;
    logic              last_reg;
    spq_rec_t          out_rec_reg;

    logic              emit_valid;
    kind_t             emit_kind;
    logic              emit_ok;
    logic              emit_last;
    spq_rec_t          emit_rec;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    spq_rec_t          ram_wdata;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [REC_W-1:0]  ram_rdata;
    spq_rec_t          rd_rec;

    logic              div_start;
    logic [ES_W-1:0]   div_divisor;
    logic              div_done;
    logic [VB_W-1:0]   stride;

    logic              accept;
    spq_rec_t          adv_rec;
    spq_rec_t          seed_rec;
    spq_rec_t          mark_rec;

    function automatic logic [PTR_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= SUM_W'(QUEUE_DEPTH)) ? s - SUM_W'(QUEUE_DEPTH) : s;
        return t[PTR_W-1:0];
    endfunction

    function automatic spq_rec_t advance(input spq_rec_t r, input logic [VB_W-1:0] s);
        spq_rec_t          n;
        logic [ADDR_W-1:0] sx;
        sx            = ADDR_W'(s);
        n             = r;
        n.id          = r.id + ID_W'(1);
        n.done        = 1'b0;
        n.ready       = '0;
        n.addr_first  = r.addr_first + sx;
        n.addr_second = r.is_move ? '0 : r.addr_second + sx;
        n.addr_dest   = r.addr_dest + sx;
        return n;
    endfunction

    spq_ram #(
        .WIDTH(REC_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    spq_stride_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(vb_reg),
        .divisor (div_divisor),
        .done    (div_done),
        .stride  (stride)
    );

    assign rd_rec  = spq_rec_t'(ram_rdata);
    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign adv_rec = advance(base_reg, stride);

    always_comb
    begin
        seed_rec.id          = conv_id;
        seed_rec.addr_first  = addr_first;
        seed_rec.addr_second = addr_second;
        seed_rec.addr_dest   = addr_dest;
        seed_rec.elem_size   = elem_size;
        seed_rec.is_move     = is_move;
        seed_rec.done        = 1'b0;
        seed_rec.ready       = '0;
        mark_rec             = rd_rec;
        mark_rec.done        = 1'b1;
        mark_rec.ready       = rdy_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        cmd_next       = cmd_reg;
        cid_next       = cid_reg;
        rdy_next       = rdy_reg;
        base_next      = base_reg;
        emit_valid     = 1'b0;
        emit_kind      = KIND_NEW;
        emit_ok        = 1'b0;
        emit_last      = 1'b1;
        emit_rec       = '0;
        ram_we         = 1'b0;
        ram_waddr      = wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg));
        ram_wdata      = adv_rec;
        ram_re         = 1'b0;
        ram_raddr      = head_reg;
        div_start      = 1'b0;
        div_divisor    = rd_rec.elem_size;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    cid_next = conv_id;
                    rdy_next = ready_cycle;
                    unique case (command) inside
                        CMD_FILL:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                state_next = S_IDLE;
                            end
                            else if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg)
                                                      - SUM_W'(1));
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                base_next   = seed_rec;
                                div_start   = 1'b1;
                                div_divisor = elem_size;
                                state_next  = S_DIV;
                            end
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                emit_valid = 1'b1;
                                emit_kind  = (command == CMD_POP) ? KIND_POP : KIND_PEEK;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                state_next = S_RDWAIT;
                            end
                        end
                        CMD_CMPL:
                        begin
                            scan_idx_next = '0;
                            pend_next     = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                if (cmd_reg == CMD_FILL)
                begin
                    base_next   = rd_rec;
                    div_start   = 1'b1;
                    div_divisor = rd_rec.elem_size;
                    state_next  = S_DIV;
                end
                else
                begin
                    emit_valid = 1'b1;
                    emit_kind  = (cmd_reg == CMD_POP) ? KIND_POP : KIND_PEEK;
                    emit_ok    = 1'b1;
                    emit_rec   = rd_rec;
                    if (cmd_reg == CMD_POP)
                    begin
                        head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                     : head_reg + PTR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                ram_we     = 1'b1;
                emit_valid = 1'b1;
                emit_kind  = KIND_NEW;
                emit_ok    = 1'b1;
                emit_rec   = adv_rec;
                emit_last  = (count_reg + CNT_W'(1) == CNT_W'(QUEUE_DEPTH));
                count_next = count_reg + CNT_W'(1);
                base_next  = adv_rec;
                if (emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // one read issued per cycle; the previous read is compared here
                if (pend_reg && rd_rec.id == cid_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pend_addr_reg;
                    ram_wdata  = mark_rec;
                    emit_valid = 1'b1;
                    emit_kind  = KIND_CMPL;
                    emit_ok    = 1'b1;
                    emit_rec   = mark_rec;
                    state_next = S_IDLE;
                end
                else if (scan_idx_reg < count_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = wrap_idx(SUM_W'(head_reg) + SUM_W'(scan_idx_reg));
                    pend_next      = 1'b1;
                    pend_addr_next = ram_raddr;
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    emit_valid = 1'b1;
                    emit_kind  = KIND_CMPL;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            vb_reg       <= VB_RESET;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            strobe_reg   <= emit_valid;
            if (vector_bytes_we)
            begin
                vb_reg <= vector_bytes_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        cmd_reg       <= cmd_next;
        cid_reg       <= cid_next;
        rdy_reg       <= rdy_next;
        base_reg      <= base_next;
        if (emit_valid)
        begin
            kind_reg    <= emit_kind;
            ok_reg      <= emit_ok;
            last_reg    <= emit_last;
            out_rec_reg <= emit_rec;
        end
    end

    assign result_strobe   = strobe_reg;
    assign kind            = kind_reg;
    assign ok              = ok_reg;
    assign last            = last_reg;
    assign rec_id          = out_rec_reg.id;
    assign rec_addr_first  = out_rec_reg.addr_first;
    assign rec_addr_second = out_rec_reg.addr_second;
    assign rec_addr_dest   = out_rec_reg.addr_dest;
    assign rec_elem_size   = out_rec_reg.elem_size;
    assign rec_is_move     = out_rec_reg.is_move;
    assign rec_done        = out_rec_reg.done;
    assign rec_ready       = out_rec_reg.ready;

    a_full_fill_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_FILL && count_reg == CNT_W'(QUEUE_DEPTH))
        |=> !result_strobe)
        else $error("fill on full queue produced a result");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_POP || command == CMD_PEEK) && count_reg == '0)
        |=> (result_strobe && !ok && last && count_reg == '0))
        else $error("empty pop/peek not flagged");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |-> !busy)
        else $error("busy still high after final result");

    a_fill_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && kind == KIND_NEW) |-> (ok && $past(count_reg) != CNT_W'(QUEUE_DEPTH)))
        else $error("new record issued without room");

endmodule

[rtl/spq_ram.sv]
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/spq_stride_div.sv]
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
// stride = dividend - (dividend mod divisor), or 0 for a zero divisor.
module spq_stride_div
    import spq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [VB_W-1:0] dividend,
    input  logic [ES_W-1:0] divisor,
    output logic            done,
    output logic [VB_W-1:0] stride
);

    localparam int STEP_W = $clog2(VB_W + 1);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ES_W:0]     rem_reg, rem_next;
    logic [VB_W-1:0]   shift_reg, shift_next;
    logic [VB_W-1:0]   dvd_reg, dvd_next;
    logic [ES_W-1:0]   dvs_reg, dvs_next;
    logic [ES_W:0]     trial;

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        rem_next    = rem_reg;
        shift_next  = shift_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        trial       = {rem_reg[ES_W-1:0], shift_reg[VB_W-1]};
        if (start)
        begin
            active_next = 1'b1;
            step_next   = STEP_W'(VB_W);
            rem_next    = '0;
            shift_next  = dividend;
            dvd_next    = dividend;
            dvs_next    = divisor;
        end
        else if (active_reg)
        begin
            rem_next   = (trial >= {1'b0, dvs_reg}) ? trial - {1'b0, dvs_reg} : trial;
            shift_next = {shift_reg[VB_W-2:0], 1'b0};
            step_next  = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
    end

    assign done   = done_reg;
    assign stride = (dvs_reg == '0) ? '0 : dvd_reg - VB_W'(rem_reg);

endmodule
